// File: hw/rtl/ffpa_pkg.sv
// Shared constants, operation codes and sequencer state type for the page allocator.
// No dependencies; compiled first.
package ffpa_pkg;

    // Fixed field widths of the request, response and configuration beats
    localparam int KIND_W = 2;
    localparam int PAGE_W = 10;
    localparam int CNT_W  = 11;

    // Built page count and bitmap word width (pages per memory row)
    localparam int MAX_PAGES_DEF = 1024;
    localparam int WORD_W        = 16;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 11'd1024;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MSTART,
        S_MARK,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/ffpa_cfg_if.sv
// Configuration write channel: valid/ready plus the active page count.
// Depends on ffpa_pkg.
interface ffpa_cfg_if
    import ffpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ffpa_req_if.sv
// Request channel: one beat per allocate, free or initialise operation.
// Depends on ffpa_pkg.
interface ffpa_req_if
    import ffpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] start_page;
    logic [CNT_W-1:0]  page_count;

    modport source (output valid, output kind, output start_page, output page_count,
                    input ready);
    modport sink   (input valid, input kind, input start_page, input page_count,
                    output ready);
endinterface

// File: hw/rtl/ffpa_rsp_if.sv
// Response channel: one beat per request, carrying status, run start and free count.
// Depends on ffpa_pkg.
interface ffpa_rsp_if
    import ffpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              success;
    logic [PAGE_W-1:0] run_start;
    logic [CNT_W-1:0]  free_total;

    modport source (output valid, output success, output run_start, output free_total,
                    input ready);
    modport sink   (input valid, input success, input run_start, input free_total,
                    output ready);
endinterface

// File: hw/rtl/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ffpa_pkg for default sizes only.
module ffpa_ram
    import ffpa_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = MAX_PAGES_DEF / WORD_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/first_fit_page_allocator_core.sv
// First-fit contiguous page allocator: taken bitmap in a word-wide RAM, one row per cycle.
// Throughput: one item at a time; next request beat the cycle after the response loads.
// Reset: synchronous active low; counter to zero, active pages to 1024, then a clearing
//   pass over every bitmap row before the first request beat.
module first_fit_page_allocator_core
    import ffpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_cfg_if.sink   i_cfg,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);

    // Widths: CW holds 0..MAX_PAGES, PW a page index, XW room for sums of counts
    localparam int CW   = $clog2(MAX_PAGES + 1);
    localparam int PW   = $clog2(MAX_PAGES);
    localparam int XW   = ((CW > CNT_W) ? CW : CNT_W) + 1;
    localparam int LW   = $clog2(WORD_W);
    localparam int ROWS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [XW-1:0] MAX_X    = XW'(MAX_PAGES);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_active;
    logic [CW-1:0]      r_free, n_free;
    logic [RW-1:0]      r_row, n_row;       // current bitmap row
    logic [XW-1:0]      r_run, n_run;       // free run carried in from earlier rows
    logic [XW-1:0]      r_count, n_count;   // requested page count
    logic [PW-1:0]      r_lo, n_lo;         // page range being marked or cleared
    logic [PW-1:0]      r_hi, n_hi;
    logic               r_set, n_set;       // 1 marks taken, 0 clears
    logic               r_ok, n_ok;
    logic [PAGE_W-1:0]  r_run_start, n_run_start;

    // Response holding register, parts the sequencer from the consumer
    logic               r_out_valid;
    logic               r_out_success;
    logic [PAGE_W-1:0]  r_out_run_start;
    logic [CNT_W-1:0]   r_out_free;

    // Bitmap RAM
    logic               ram_we;
    logic [RW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [RW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    ffpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic            req_beat;
    logic            load_out;
    logic [XW-1:0]   act;
    logic [XW-1:0]   req_start_x, req_cnt_x, req_end_x, req_lim, req_end_c;
    logic            req_range_ne;
    logic [XW-1:0]   free_sum;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_beat    = i_req.valid && i_req.ready;

    // Active count clamps to the built map size
    assign act = (XW'(r_active) > MAX_X) ? MAX_X : XW'(r_active);

    assign req_start_x = XW'(i_req.start_page);
    assign req_cnt_x   = XW'(i_req.page_count);
    assign req_end_x   = req_start_x + req_cnt_x;
    // free stops at the active count, initialise at the end of the map
    assign req_lim     = (i_req.kind == KIND_FREE) ? act : MAX_X;
    assign req_end_c   = (req_end_x > req_lim) ? req_lim : req_end_x;
    assign req_range_ne = req_start_x < req_end_c;
    assign free_sum    = XW'(r_free) + req_cnt_x;

    // ------------------------------------------------------------------
    // Row scan: find the lowest page ending a free run of r_count pages
    // ------------------------------------------------------------------
    logic [XW-1:0]     base_x;
    logic [WORD_W-1:0] free_vec;
    logic [WORD_W-1:0] hit_vec;
    logic              hit_any;
    logic [LW-1:0]     hit_idx;
    logic [XW-1:0]     hit_end_x, hit_lo_x;
    logic [XW-1:0]     run_out;
    logic              scan_end;
    logic [XW-1:0]     alloc_free;

    assign base_x = XW'({r_row, {LW{1'b0}}});

    // Pages past the active count count as taken, so no run crosses them
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            free_vec[j] = !ram_rdata[j] && ((base_x + XW'(j)) < act);
        end
    end

    always_comb begin : scan_eval
        logic [WORD_W-1:0] lowm;
        logic [WORD_W-1:0] win;
        logic [LW:0]       sh;
        hit_vec = '0;
        for (int j = 0; j < WORD_W; j++) begin
            lowm = {WORD_W{1'b1}} >> (WORD_W - 1 - j);
            win  = '0;
            sh   = '0;
            if (r_count <= XW'(j + 1)) begin
                // run lies wholly within this row
                sh         = (LW + 1)'(j + 1) - r_count[LW:0];
                win        = lowm & ({WORD_W{1'b1}} << sh);
                hit_vec[j] = ((free_vec & win) == win);
            end else begin
                // run continues from earlier rows
                hit_vec[j] = (&(free_vec | ~lowm)) && ((r_run + XW'(j + 1)) >= r_count);
            end
        end
    end

    always_comb begin : scan_pick
        logic [LW-1:0] top_taken;
        logic [LW-1:0] top_free;
        logic          any_taken;
        hit_idx   = '0;
        top_taken = '0;
        any_taken = 1'b0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_idx = LW'(j);
            end
        end
        for (int k = 0; k < WORD_W; k++) begin
            if (!free_vec[k]) begin
                top_taken = LW'(k);
                any_taken = 1'b1;
            end
        end
        // free pages above the highest taken one
        top_free = ~top_taken;
        run_out  = any_taken ? XW'(top_free) : (r_run + XW'(WORD_W));
    end

    assign hit_any    = |hit_vec;
    assign hit_end_x  = base_x + XW'(hit_idx);
    assign hit_lo_x   = hit_end_x + XW'(1) - r_count;
    assign scan_end   = (base_x + XW'(WORD_W)) >= act;
    assign alloc_free = (XW'(r_free) > r_count) ? (XW'(r_free) - r_count) : '0;

    // ------------------------------------------------------------------
    // Range marking: mask of the current row that falls inside [r_lo, r_hi]
    // ------------------------------------------------------------------
    logic [RW-1:0]     lo_row, hi_row;
    logic [LW-1:0]     lo_bit, hi_bit;
    logic [WORD_W-1:0] row_mask;

    assign lo_row   = RW'(r_lo >> LW);
    assign hi_row   = RW'(r_hi >> LW);
    assign lo_bit   = (r_row == lo_row) ? LW'(r_lo) : '0;
    assign hi_bit   = (r_row == hi_row) ? ~LW'(r_hi) : '0;
    assign row_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> hi_bit);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_row == LAST_ROW) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_beat) begin
                    case (i_req.kind)
                        KIND_ALLOC: begin
                            n_state = (req_cnt_x != '0 && req_cnt_x <= act) ? S_SCAN : S_DONE;
                        end
                        KIND_FREE, KIND_INIT: begin
                            n_state = req_range_ne ? S_MSTART : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit_any) begin
                    n_state = S_MSTART;
                end else if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_MSTART: n_state = S_MARK;
            S_MARK: begin
                if (r_row == hi_row) n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath updates and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        n_row       = r_row;
        n_run       = r_run;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_ok        = r_ok;
        n_run_start = r_run_start;
        n_free      = r_free;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = '0;
        ram_raddr   = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_row  = (r_row == LAST_ROW) ? '0 : r_row + RW'(1);
            end
            S_IDLE: begin
                if (req_beat) begin
                    n_row       = '0;
                    n_run       = '0;
                    n_count     = req_cnt_x;
                    n_ok        = 1'b0;
                    n_run_start = '0;
                    n_set       = 1'b0;
                    n_lo        = PW'(req_start_x);
                    n_hi        = PW'(req_end_c - XW'(1));
                    case (i_req.kind)
                        KIND_FREE: begin
                            if (req_start_x < act) begin
                                n_ok   = 1'b1;
                                n_free = CW'((free_sum > MAX_X) ? MAX_X : free_sum);
                            end
                        end
                        KIND_INIT: begin
                            n_ok   = 1'b1;
                            n_free = CW'((req_cnt_x > MAX_X) ? MAX_X : req_cnt_x);
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                ram_raddr = r_row + RW'(1);
                if (hit_any) begin
                    n_lo        = PW'(hit_lo_x);
                    n_hi        = PW'(hit_end_x);
                    n_set       = 1'b1;
                    n_ok        = 1'b1;
                    n_run_start = PAGE_W'(hit_lo_x);
                    n_free      = CW'(alloc_free);
                end else begin
                    n_row = r_row + RW'(1);
                    n_run = run_out;
                end
            end
            S_MSTART: begin
                ram_raddr = lo_row;
                n_row     = lo_row;
            end
            S_MARK: begin
                // read-modify-write, next row's read overlaps this row's write
                ram_raddr = r_row + RW'(1);
                ram_we    = 1'b1;
                ram_wdata = r_set ? (ram_rdata | row_mask) : (ram_rdata & ~row_mask);
                n_row     = r_row + RW'(1);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_active    <= ACTIVE_RESET;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_free  <= n_free;
            if (i_cfg.valid && i_cfg.ready) begin
                r_active <= i_cfg.data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run       <= n_run;
        r_count     <= n_count;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_ok        <= n_ok;
        r_run_start <= n_run_start;
        if (load_out) begin
            r_out_success   <= r_ok;
            r_out_run_start <= r_run_start;
            r_out_free      <= CNT_W'(XW'(r_free));
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.success    = r_out_success;
    assign o_rsp.run_start  = r_out_run_start;
    assign o_rsp.free_total = r_out_free;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // counter never passes the built map size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_free) <= MAX_X)
        else $error("free counter above map size");

    // marking only touches rows of the recorded range
    a_mark_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_row >= lo_row && r_row <= hi_row))
        else $error("mark row outside range");

    // a granted run is exactly the requested length
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit_any) |=> ((XW'(r_hi) - XW'(r_lo) + XW'(1)) == r_count))
        else $error("granted run length mismatch");

    // no result beat is dropped while the consumer stalls
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("result overwritten under stall");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for first_fit_page_allocator_core: first-fit allocate, free and initialise.
// Needs ffpa_pkg, the ffpa_cfg_if/ffpa_req_if/ffpa_rsp_if interfaces and the core RTL.
// A class mirrors the page bitmap and free counter and checks each response beat in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffpa_pkg::*;

    localparam int PAGES = MAX_PAGES_DEF;
    // Kind code the core does not decode; it must come back as a plain reject
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    // Cycles allowed for outstanding responses to drain at a phase boundary or the end
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic              success;
        logic [PAGE_W-1:0] run_start;
        logic [CNT_W-1:0]  free_total;
    } t_alloc_rsp;

    // One granted run, kept so that well-formed frees can hand it back later
    typedef struct {
        logic [PAGE_W-1:0] first;
        logic [CNT_W-1:0]  len;
    } t_run;

    // Page book: own copy of the taken bitmap, counter and active-page register,
    // plus the responses still owed by the core, oldest first.
    class t_page_book;
        bit               taken[PAGES];
        int               free_cnt;
        int               active;
        t_alloc_rsp       owed[$];
        int               fails;
        int               grants;
        int               rejects;

        function new();
            foreach (taken[p])
                taken[p] = 1'b0;
            free_cnt = 0;
            active   = int'(ACTIVE_RESET);
            fails    = 0;
            grants   = 0;
            rejects  = 0;
        endfunction

        function void set_active(logic [CNT_W-1:0] v);
            active = int'(v);
        endfunction

        function int eff_active();
            return (active > PAGES) ? PAGES : active;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted request beat to the mirror and queue its response
        function t_alloc_rsp note_req(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] start,
                                      logic [CNT_W-1:0] count);
            t_alloc_rsp r;
            int act;
            int s;
            int c;
            int run;
            int first;
            int i;
            int k;
            r     = '0;
            act   = eff_active();
            s     = int'(start);
            c     = int'(count);
            run   = 0;
            case (kind)
                KIND_ALLOC: begin
                    if (c != 0 && c <= act) begin
                        for (i = 0; i < act; i++) begin
                            run = taken[i] ? 0 : run + 1;
                            if (run == c) begin
                                first = i + 1 - c;
                                for (k = first; k <= i; k++)
                                    taken[k] = 1'b1;
                                free_cnt    = (free_cnt > c) ? free_cnt - c : 0;
                                r.success   = 1'b1;
                                r.run_start = first[PAGE_W-1:0];
                                break;
                            end
                        end
                    end
                end
                KIND_FREE: begin
                    if (s < act) begin
                        for (i = 0; i < c && s + i < act; i++)
                            taken[s + i] = 1'b0;
                        free_cnt  = (free_cnt + c > PAGES) ? PAGES : free_cnt + c;
                        r.success = 1'b1;
                    end
                end
                KIND_INIT: begin
                    for (i = 0; i < c && s + i < PAGES; i++)
                        taken[s + i] = 1'b0;
                    free_cnt  = (c > PAGES) ? PAGES : c;
                    r.success = 1'b1;
                end
                default: ;
            endcase
            r.free_total = free_cnt[CNT_W-1:0];
            if (kind == KIND_ALLOC && r.success)
                grants++;
            if (!r.success)
                rejects++;
            owed.push_back(r);
            return r;
        endfunction

        function void check_rsp(t_alloc_rsp got);
            t_alloc_rsp want;
            if (owed.size() == 0) begin
                $error({"response beat with nothing outstanding: ",
                        "success=%0d run_start=%0d free_total=%0d"},
                       got.success, got.run_start, got.free_total);
                fails++;
                return;
            end
            want = owed.pop_front();
            if (got.success !== want.success) begin
                $error("success: expected %0d, got %0d", want.success, got.success);
                fails++;
            end
            if (got.run_start !== want.run_start) begin
                $error("run_start: expected %0d, got %0d", want.run_start, got.run_start);
                fails++;
            end
            if (got.free_total !== want.free_total) begin
                $error("free_total: expected %0d, got %0d", want.free_total, got.free_total);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffpa_cfg_if cfg_ch();
    ffpa_req_if req_ch();
    ffpa_rsp_if rsp_ch();

    first_fit_page_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_page_book book = new();
    t_run       granted[$];

    // Idling knobs, changed per phase; calm switches all idling off for the final stretch
    int gap_pct    = 0;
    int stall_pct  = 0;
    bit calm       = 1'b0;
    int stall_left = 0;
    int beats_in   = 0;
    int cfg_writes = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side: check every beat taken at this edge, then decide next cycle's ready.
    // Stalls come in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready)
                book.check_rsp({rsp_ch.success, rsp_ch.run_start, rsp_ch.free_total});
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 8);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one request beat (after an optional idle burst) and hold it until taken.
    // Granted runs are remembered so that later frees can return them whole.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] start,
                         input logic [CNT_W-1:0] count);
        t_alloc_rsp want;
        t_run       g;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.start_page <= start;
        req_ch.page_count <= count;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        want = book.note_req(kind, start, count);
        beats_in++;
        if (kind == KIND_ALLOC && want.success) begin
            g.first = want.run_start;
            g.len   = count;
            granted.push_back(g);
        end
    endtask

    task automatic park_req();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every owed response has come back (bounded)
    task automatic drain();
        int waited;
        waited = 0;
        while (book.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic write_active(input logic [CNT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        book.set_active(v);
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Core idle, then move to a new active page count with fresh idling odds
    task automatic new_phase(input logic [CNT_W-1:0] v);
        int odds[3];
        odds = '{0, 15, 40};
        park_req();
        drain();
        write_active(v);
        gap_pct   = odds[$urandom_range(0, 2)];
        stall_pct = odds[$urandom_range(0, 2)];
        granted.delete();
    endtask

    // Random traffic: mostly first-fit allocations and returns of granted runs,
    // some whole-map initialisations, and a share of arbitrary beats as noise.
    task automatic random_ops(input int n);
        int   j;
        int   pick;
        int   act;
        int   lim;
        int   idx;
        t_run g;
        for (j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            act  = book.eff_active();
            lim  = (act < 32) ? act : 32;
            if (pick < 75 && pick >= 45 && granted.size() > 0) begin
                idx = $urandom_range(0, granted.size() - 1);
                g   = granted[idx];
                granted.delete(idx);
                issue(KIND_FREE, g.first, g.len);
            end else if (pick < 75) begin
                if (act == 0)
                    issue(KIND_ALLOC, PAGE_W'($urandom), CNT_W'($urandom_range(0, 3)));
                else if ($urandom_range(0, 9) == 0)
                    issue(KIND_ALLOC, PAGE_W'($urandom), CNT_W'($urandom_range(1, act)));
                else
                    issue(KIND_ALLOC, PAGE_W'($urandom), CNT_W'($urandom_range(1, lim)));
            end else if (pick < 83) begin
                granted.delete();
                if ($urandom_range(0, 9) < 7)
                    issue(KIND_INIT, '0, CNT_W'(act));
                else
                    issue(KIND_INIT, PAGE_W'($urandom), CNT_W'($urandom_range(0, 2047)));
            end else begin
                issue(KIND_W'($urandom_range(0, 3)), PAGE_W'($urandom),
                      CNT_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_ALLOC;
        req_ch.start_page <= '0;
        req_ch.page_count <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset value of the register (full 1024-page map)
        issue(KIND_ALLOC, '0, 11'd1);          // counter starts at zero: saturates
        issue(KIND_INIT, '0, 11'd1024);
        issue(KIND_ALLOC, '0, 11'd0);          // zero-length request fails
        issue(KIND_ALLOC, '0, 11'd1025);       // longer than the active map
        issue(KIND_ALLOC, 10'd1023, 11'd2047);
        issue(KIND_ALLOC, '0, 11'd1024);       // whole map in one run
        issue(KIND_ALLOC, '0, 11'd1);          // map full: no run
        issue(KIND_FREE, 10'd1023, 11'd1);
        issue(KIND_ALLOC, '0, 11'd1);          // lands on the last page
        issue(KIND_FREE, 10'd1000, 11'd2047);  // clears to the end, counter saturates high
        issue(KIND_FREE, '0, 11'd0);
        issue(KIND_SPARE, 10'd1023, 11'd2047); // undecoded kind
        issue(KIND_INIT, 10'd1023, 11'd2047);  // clearing stops at the end of the map
        issue(KIND_INIT, 10'd512, 11'd0);
        issue(KIND_ALLOC, '0, 11'd16);         // first hole is at page 1000
        issue(KIND_FREE, '0, 11'd512);
        issue(KIND_ALLOC, '0, 11'd512);
        issue(KIND_INIT, '0, 11'd1024);

        // One active page: start past the end is ignored, frees clip at the end
        new_phase(11'd1);
        issue(KIND_FREE, 10'd1, 11'd1);
        issue(KIND_ALLOC, '0, 11'd2);
        issue(KIND_ALLOC, '0, 11'd1);
        issue(KIND_FREE, '0, 11'd5);
        random_ops(40);

        // No active pages: allocate and free always fail, initialise still works
        new_phase(11'd0);
        issue(KIND_ALLOC, '0, 11'd1);
        issue(KIND_FREE, '0, 11'd1);
        issue(KIND_INIT, '0, 11'd8);
        random_ops(20);

        new_phase(11'd1024);
        random_ops(400);
        new_phase(11'd2047);                   // clamps to the built maximum
        random_ops(200);
        new_phase(11'd16);                     // exactly one bitmap row
        random_ops(100);
        new_phase(11'd17);                     // one page into the second row
        random_ops(100);
        new_phase(11'd100);
        random_ops(200);
        new_phase(CNT_W'($urandom_range(1, 1024)));
        random_ops(200);

        // Final stretch at full size, no idling on either side
        new_phase(11'd1024);
        calm = 1'b1;
        random_ops(300);

        park_req();
        drain();
        repeat (200) @(posedge i_clk);
        if (book.pending() != 0) begin
            $error("%0d response beats never arrived", book.pending());
            book.fails++;
        end
        $display("Covered %0d request beats over %0d active-page settings:",
                 beats_in, cfg_writes);
        $display("%0d runs granted, %0d rejected.", book.grants, book.rejects);
        if (book.fails == 0)
            $display("first_fit_page_allocator_core regression: pass");
        else
            $display("first_fit_page_allocator_core regression: fail");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #10ms;
        $display("first_fit_page_allocator_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_cfg_if.sv
hw/rtl/ffpa_req_if.sv
hw/rtl/ffpa_rsp_if.sv
hw/rtl/ffpa_ram.sv
hw/rtl/first_fit_page_allocator_core.sv
bench/tb.sv
